// ===== sv/mdnp_pkg.sv =====
// ----------------------------------------------------------------------------
// mdnp_pkg
// Shared types and constants of the mouse delta nibble port.
// ----------------------------------------------------------------------------
package mdnp_pkg;

    typedef enum logic [1:0] {
        CMD_REPORT = 2'd0,
        CMD_READ   = 2'd1,
        CMD_TICK   = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    localparam int unsigned QUEUE_DEPTH = 2;

    localparam logic signed [11:0] XY_MAX    = 12'sd2047;
    localparam logic signed [7:0]  WHEEL_MAX = 8'sd127;
    localparam logic signed [7:0]  WHEEL_MIN = -8'sd128;
    localparam logic [4:0]         JOY_IDLE  = 5'h1f;
    localparam logic [3:0]         BTN_NONE  = 4'hf;
    localparam logic [8:0]         IDLE_MAX  = 9'd511;
    localparam logic [7:0]         TIMEOUT_RESET = 8'd40;

    localparam logic REG_TIMEOUT = 1'b0;
    localparam logic REG_PRESENT = 1'b1;

    // classified item as it waits in the queue
    typedef struct packed {
        cmd_t              cmd;
        logic signed [6:0] step_x;
        logic signed [6:0] step_y;
        logic signed [7:0] wheel;
        logic [3:0]        buttons;
        logic [4:0]        joystick;
    } item_t;

    // queue head as seen by the back end
    typedef struct packed {
        logic  valid;
        item_t item;
    } head_t;

endpackage

// ===== sv/mdnp_front.sv =====
// ----------------------------------------------------------------------------
// mdnp_front
// Accepts input items, scales the movement, remaps the buttons and queues
// the result for the back end. Unused command codes are dropped here.
// ----------------------------------------------------------------------------
module mdnp_front import mdnp_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [1:0]        s_cmd,
    input  logic signed [7:0] s_move_x,
    input  logic signed [7:0] s_move_y,
    input  logic signed [7:0] s_wheel_move,
    input  logic [2:0]        s_button_bits,
    input  logic [4:0]        s_joystick,
    output head_t             head,
    input  logic              pop
);

    localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

    item_t             q_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    item_t             new_item;
    logic signed [8:0] inc_x;
    logic signed [8:0] inc_y;
    logic              push;

    // (d + 1) >> 2 with floor
    assign inc_x = 9'(s_move_x) + 9'sd1;
    assign inc_y = 9'(s_move_y) + 9'sd1;

    always_comb begin
        new_item.cmd      = cmd_t'(s_cmd);
        new_item.step_x   = 7'(inc_x >>> 2);
        new_item.step_y   = 7'(inc_y >>> 2);
        new_item.wheel    = s_wheel_move;
        // active-low left, right in bit 2, middle in bit 1, bit 3 set
        new_item.buttons  = {1'b0, s_button_bits[1], s_button_bits[2], s_button_bits[0]}
                            ^ BTN_NONE;
        new_item.joystick = s_joystick;
    end

    assign s_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign push    = s_valid && s_ready && (cmd_t'(s_cmd) != CMD_NONE);

    assign head.valid = (count_reg != '0);
    assign head.item  = q_mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem[wr_ptr_reg] <= new_item;
        end
    end

endmodule

// ===== sv/mdnp_back.sv =====
// ----------------------------------------------------------------------------
// mdnp_back
// Carries out queued items: accumulates movement, runs the nine-phase read
// sequence, counts idle ticks and holds the result in an output register.
// ----------------------------------------------------------------------------
module mdnp_back import mdnp_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data,
    input  head_t       head,
    output logic        pop,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [4:0]  m_port_value,
    output logic        m_from_timeout
);

    typedef enum logic [8:0] {
        PH0 = 9'b000000001,
        PH1 = 9'b000000010,
        PH2 = 9'b000000100,
        PH3 = 9'b000001000,
        PH4 = 9'b000010000,
        PH5 = 9'b000100000,
        PH6 = 9'b001000000,
        PH7 = 9'b010000000,
        PH8 = 9'b100000000
    } phase_t;

    function automatic logic signed [11:0] sat_xy(input logic signed [12:0] v);
        logic signed [11:0] r;
        if (v > 13'(XY_MAX)) begin
            r = XY_MAX;
        end else if (v < -13'(XY_MAX)) begin
            r = -XY_MAX;
        end else begin
            r = v[11:0];
        end
        return r;
    endfunction

    function automatic logic signed [7:0] sat_wheel(input logic signed [8:0] v);
        logic signed [7:0] r;
        if (v > 9'(WHEEL_MAX)) begin
            r = WHEEL_MAX;
        end else if (v < 9'(WHEEL_MIN)) begin
            r = WHEEL_MIN;
        end else begin
            r = v[7:0];
        end
        return r;
    endfunction

    logic [7:0]         timeout_reg;
    logic               present_reg;

    logic signed [11:0] acc_x_reg, acc_x_next;
    logic signed [11:0] acc_y_reg, acc_y_next;
    logic signed [7:0]  acc_w_reg, acc_w_next;
    logic [3:0]         live_btn_reg, live_btn_next;
    logic signed [11:0] snap_x_reg, snap_x_next;
    logic signed [11:0] snap_y_reg, snap_y_next;
    logic signed [7:0]  snap_w_reg, snap_w_next;
    logic [3:0]         snap_btn_reg, snap_btn_next;
    phase_t             phase_reg, phase_next;
    logic [8:0]         idle_reg, idle_next;

    logic               m_valid_reg, m_valid_next;
    logic [4:0]         value_reg;
    logic               timeout_flag_reg;

    item_t              it;
    logic signed [11:0] upd_acc_x, upd_acc_y, upd_snap_x, upd_snap_y;
    logic signed [7:0]  upd_acc_w, upd_snap_w;
    logic [8:0]         idle_inc;
    logic               snap_idle;
    logic               res_fire;
    logic [4:0]         res_value;
    logic               res_timeout;

    assign it  = head.item;
    assign pop = head.valid && (!m_valid_reg || m_ready);

    assign upd_acc_x  = sat_xy(13'(acc_x_reg) + 13'($signed(it.step_x)));
    assign upd_acc_y  = sat_xy(13'(acc_y_reg) + 13'($signed(it.step_y)));
    assign upd_acc_w  = sat_wheel(9'(acc_w_reg) + 9'($signed(it.wheel)));
    assign upd_snap_x = sat_xy(13'(snap_x_reg) + 13'(acc_x_reg));
    // y is reported up positive
    assign upd_snap_y = sat_xy(13'(snap_y_reg) - 13'(acc_y_reg));
    assign upd_snap_w = sat_wheel(9'(snap_w_reg) + 9'(acc_w_reg));
    assign idle_inc   = (idle_reg == IDLE_MAX) ? idle_reg : idle_reg + 1'b1;

    // nothing to report: serve the joystick straight away
    assign snap_idle = (live_btn_reg[2:0] == BTN_NONE[2:0]) && (upd_snap_x == '0)
                       && (upd_snap_y == '0) && (upd_snap_w == '0)
                       && (it.joystick != JOY_IDLE);

    always_comb begin
        acc_x_next    = acc_x_reg;
        acc_y_next    = acc_y_reg;
        acc_w_next    = acc_w_reg;
        live_btn_next = live_btn_reg;
        snap_x_next   = snap_x_reg;
        snap_y_next   = snap_y_reg;
        snap_w_next   = snap_w_reg;
        snap_btn_next = snap_btn_reg;
        phase_next    = phase_reg;
        idle_next     = idle_reg;
        res_fire      = 1'b0;
        res_value     = it.joystick;
        res_timeout   = 1'b0;
        if (pop) begin
            unique case (it.cmd)
                CMD_REPORT: begin
                    acc_x_next    = upd_acc_x;
                    acc_y_next    = upd_acc_y;
                    acc_w_next    = upd_acc_w;
                    live_btn_next = it.buttons;
                end
                CMD_TICK: begin
                    idle_next = idle_inc;
                    if (phase_reg != PH0 && idle_inc > {1'b0, timeout_reg}) begin
                        phase_next  = PH0;
                        res_fire    = 1'b1;
                        res_timeout = 1'b1;
                    end
                end
                CMD_READ: begin
                    idle_next = '0;
                    res_fire  = 1'b1;
                    if (present_reg) begin
                        unique case (phase_reg)
                            PH0: begin
                                snap_x_next   = upd_snap_x;
                                snap_y_next   = upd_snap_y;
                                snap_w_next   = upd_snap_w;
                                snap_btn_next = live_btn_reg;
                                acc_x_next    = '0;
                                acc_y_next    = '0;
                                acc_w_next    = '0;
                                if (!snap_idle) begin
                                    res_value  = JOY_IDLE;
                                    phase_next = PH1;
                                end
                            end
                            PH1: begin
                                res_value  = {snap_w_reg[6], snap_btn_reg};
                                phase_next = PH2;
                            end
                            PH2: begin
                                res_value  = {snap_w_reg[5], snap_y_reg[11:8]};
                                phase_next = PH3;
                            end
                            PH3: begin
                                res_value  = {snap_w_reg[4], snap_y_reg[7:4]};
                                phase_next = PH4;
                            end
                            PH4: begin
                                res_value  = {snap_w_reg[3], snap_y_reg[3:0]};
                                phase_next = PH5;
                            end
                            PH5: begin
                                res_value  = {snap_w_reg[2], snap_x_reg[11:8]};
                                phase_next = PH6;
                            end
                            PH6: begin
                                res_value  = {snap_w_reg[1], snap_x_reg[7:4]};
                                phase_next = PH7;
                            end
                            PH7: begin
                                res_value  = {snap_w_reg[0], snap_x_reg[3:0]};
                                phase_next = PH8;
                            end
                            PH8: begin
                                snap_x_next = '0;
                                snap_y_next = '0;
                                snap_w_next = '0;
                                phase_next  = PH0;
                            end
                            default: begin
                                phase_next = PH0;
                            end
                        endcase
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        if (res_fire) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg  <= TIMEOUT_RESET;
            present_reg  <= 1'b0;
            acc_x_reg    <= '0;
            acc_y_reg    <= '0;
            acc_w_reg    <= '0;
            live_btn_reg <= BTN_NONE;
            snap_x_reg   <= '0;
            snap_y_reg   <= '0;
            snap_w_reg   <= '0;
            snap_btn_reg <= '0;
            phase_reg    <= PH0;
            idle_reg     <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_valid) begin
                unique case (cfg_index)
                    REG_TIMEOUT: timeout_reg <= cfg_data;
                    REG_PRESENT: present_reg <= cfg_data[0];
                    default: begin
                    end
                endcase
            end
            acc_x_reg    <= acc_x_next;
            acc_y_reg    <= acc_y_next;
            acc_w_reg    <= acc_w_next;
            live_btn_reg <= live_btn_next;
            snap_x_reg   <= snap_x_next;
            snap_y_reg   <= snap_y_next;
            snap_w_reg   <= snap_w_next;
            snap_btn_reg <= snap_btn_next;
            phase_reg    <= phase_next;
            idle_reg     <= idle_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_fire) begin
            value_reg        <= res_value;
            timeout_flag_reg <= res_timeout;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_port_value   = value_reg;
    assign m_from_timeout = timeout_flag_reg;

endmodule

// ===== sv/mouse_delta_nibble_port.sv =====
// ----------------------------------------------------------------------------
// mouse_delta_nibble_port
// Accumulates mouse movement and serves it, with the buttons and wheel, as
// five-bit port values in a nine-phase read sequence with joystick fallback.
//
//   channel   ports                                   direction
//   s_        cmd, move_x, move_y, wheel_move,        in  (valid/ready)
//             button_bits, joystick
//   m_        port_value, from_timeout                out (valid/ready)
//   cfg_      index (0 timeout_ticks, 1 present),     in  (valid/ready)
//             data
//
// One item per cycle sustained while m_ready keeps up; a result goes through
// the queue stage, then the output register, after its item's transfer.
// The two-entry queue lets the input side keep going while a result waits.
// aresetn is synchronous; it clears the queue, the accumulators and phase.
// cfg_ready is always high; writes with no item in flight are the user's duty.
// ----------------------------------------------------------------------------
module mouse_delta_nibble_port import mdnp_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [1:0]        s_cmd,
    input  logic signed [7:0] s_move_x,
    input  logic signed [7:0] s_move_y,
    input  logic signed [7:0] s_wheel_move,
    input  logic [2:0]        s_button_bits,
    input  logic [4:0]        s_joystick,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [4:0]        m_port_value,
    output logic              m_from_timeout,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic              cfg_index,
    input  logic [7:0]        cfg_data
);

    head_t head;
    logic  pop;

    assign cfg_ready = 1'b1;

    mdnp_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_cmd         (s_cmd),
        .s_move_x      (s_move_x),
        .s_move_y      (s_move_y),
        .s_wheel_move  (s_wheel_move),
        .s_button_bits (s_button_bits),
        .s_joystick    (s_joystick),
        .head          (head),
        .pop           (pop)
    );

    mdnp_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .head           (head),
        .pop            (pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_port_value   (m_port_value),
        .m_from_timeout (m_from_timeout)
    );

endmodule

// ===== sv/mdnp_checker.sv =====
// ----------------------------------------------------------------------------
// mdnp_checker
// Port-level checks on the mouse delta nibble port.
// ----------------------------------------------------------------------------
module mdnp_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_ready,
    input logic              m_valid,
    input logic              m_ready,
    input logic [4:0]        m_port_value,
    input logic              m_from_timeout
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_port_value) && $stable(m_from_timeout))
        else $error("result changed while stalled");

    // reset leaves no result pending and the input open
    a_reset_state: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("bad state after reset");

    // the queue fills only behind a result that is not taken
    a_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid)
        else $error("input stalled with no pending result");

    // a timeout restart cannot come straight out of reset
    a_timeout_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(!aresetn) |=> !(m_valid && m_from_timeout))
        else $error("timeout result too soon after reset");

endmodule

bind mouse_delta_nibble_port mdnp_checker u_mdnp_checker (.*);

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the mouse delta nibble port. Host events (reports,
// read strobes, microsecond ticks) are queued, driven with random gaps, and
// fed to a cycle-free model of the port that predicts every emitted value.
// Results are compared in order, with random back-pressure on the m_ side.
// ----------------------------------------------------------------------------
module tb_top import mdnp_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        cmd_t              cmd;
        logic signed [7:0] mx;
        logic signed [7:0] my;
        logic signed [7:0] wheel;
        logic [2:0]        btn;
        logic [4:0]        joy;
    } host_event_t;

    typedef struct {
        logic [4:0] value;
        logic       by_timeout;
    } port_read_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic [1:0]        s_cmd = 2'd0;
    logic signed [7:0] s_move_x = '0;
    logic signed [7:0] s_move_y = '0;
    logic signed [7:0] s_wheel_move = '0;
    logic [2:0]        s_button_bits = '0;
    logic [4:0]        s_joystick = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic [4:0]        m_port_value;
    logic              m_from_timeout;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic              cfg_index = 1'b0;
    logic [7:0]        cfg_data = '0;

    host_event_t event_q[$];
    port_read_t  port_expect_q[$];
    host_event_t drv_event;
    int          mismatches = 0;
    bit          calm = 1'b0;

    // model state
    int          acc_x, acc_y, acc_wheel;
    logic [3:0]  live_btn;
    int          snap_x, snap_y, snap_wheel;
    logic [3:0]  snap_btn;
    int unsigned pm_phase;
    int unsigned idle_cnt;
    int unsigned cfg_timeout;
    bit          cfg_present;

    mouse_delta_nibble_port u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_cmd          (s_cmd),
        .s_move_x       (s_move_x),
        .s_move_y       (s_move_y),
        .s_wheel_move   (s_wheel_move),
        .s_button_bits  (s_button_bits),
        .s_joystick     (s_joystick),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_port_value   (m_port_value),
        .m_from_timeout (m_from_timeout),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic int clamp(int v, int lo, int hi);
        return (v > hi) ? hi : ((v < lo) ? lo : v);
    endfunction

    task automatic reset_port_model();
        acc_x = 0;
        acc_y = 0;
        acc_wheel = 0;
        live_btn = BTN_NONE;
        snap_x = 0;
        snap_y = 0;
        snap_wheel = 0;
        snap_btn = '0;
        pm_phase = 0;
        idle_cnt = 0;
        cfg_timeout = TIMEOUT_RESET;
        cfg_present = 1'b0;
    endtask

    task automatic step_port_model(host_event_t e);
        int          dx, dy, dw;
        int unsigned nxt;
        logic [11:0] xb, yb;
        logic [7:0]  wb;
        port_read_t  r;
        r.value = e.joy;
        r.by_timeout = 1'b0;
        case (e.cmd)
            CMD_REPORT: begin
                dx = e.mx;
                dy = e.my;
                dw = e.wheel;
                acc_x = clamp(acc_x + ((dx + 1) >>> 2), -int'(XY_MAX), int'(XY_MAX));
                acc_y = clamp(acc_y + ((dy + 1) >>> 2), -int'(XY_MAX), int'(XY_MAX));
                if (dw != 0)
                    acc_wheel = clamp(acc_wheel + dw, int'(WHEEL_MIN), int'(WHEEL_MAX));
                // left stays bit 0, right goes to bit 2, middle to bit 1
                live_btn = {1'b0, e.btn[1], e.btn[2], e.btn[0]} ^ BTN_NONE;
            end
            CMD_TICK: begin
                if (idle_cnt < IDLE_MAX)
                    idle_cnt++;
                if (pm_phase != 0 && idle_cnt > cfg_timeout) begin
                    pm_phase = 0;
                    r.by_timeout = 1'b1;
                    port_expect_q.push_back(r);
                end
            end
            CMD_READ: begin
                idle_cnt = 0;
                if (cfg_present) begin
                    if (pm_phase > 8)
                        pm_phase = 0;
                    nxt = pm_phase + 1;
                    if (pm_phase == 0) begin
                        snap_y = clamp(snap_y - acc_y, -int'(XY_MAX), int'(XY_MAX));
                        snap_x = clamp(snap_x + acc_x, -int'(XY_MAX), int'(XY_MAX));
                        snap_wheel = clamp(snap_wheel + acc_wheel, int'(WHEEL_MIN),
                                           int'(WHEEL_MAX));
                        acc_x = 0;
                        acc_y = 0;
                        acc_wheel = 0;
                        snap_btn = live_btn;
                        // idle mouse with an active joystick hands the port over
                        if (snap_btn[2:0] == 3'b111 && snap_x == 0 && snap_y == 0 &&
                            snap_wheel == 0 && e.joy != JOY_IDLE) begin
                            r.value = e.joy;
                            nxt = 0;
                        end else begin
                            r.value = JOY_IDLE;
                        end
                    end
                    xb = 12'(snap_x);
                    yb = 12'(snap_y);
                    wb = 8'(snap_wheel);
                    case (pm_phase)
                        1: r.value = {wb[6], snap_btn};
                        2: r.value = {wb[5], yb[11:8]};
                        3: r.value = {wb[4], yb[7:4]};
                        4: r.value = {wb[3], yb[3:0]};
                        5: r.value = {wb[2], xb[11:8]};
                        6: r.value = {wb[1], xb[7:4]};
                        7: r.value = {wb[0], xb[3:0]};
                        8: begin
                            r.value = e.joy;
                            snap_x = 0;
                            snap_y = 0;
                            snap_wheel = 0;
                            nxt = 0;
                        end
                        default: ;
                    endcase
                    pm_phase = nxt;
                end
                port_expect_q.push_back(r);
            end
            default: ;
        endcase
    endtask

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                step_port_model(drv_event);
            if (!s_valid || s_ready) begin
                if (event_q.size() > 0 && (calm || $urandom_range(0, 99) >= 13)) begin
                    drv_event = event_q.pop_front();
                    s_valid       <= 1'b1;
                    s_cmd         <= drv_event.cmd;
                    s_move_x      <= drv_event.mx;
                    s_move_y      <= drv_event.my;
                    s_wheel_move  <= drv_event.wheel;
                    s_button_bits <= drv_event.btn;
                    s_joystick    <= drv_event.joy;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        port_read_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (port_expect_q.size() == 0) begin
                    $display("%0t: unexpected transfer value=%h from_timeout=%b",
                             $time, m_port_value, m_from_timeout);
                    mismatches++;
                end else begin
                    want = port_expect_q.pop_front();
                    if (m_port_value !== want.value) begin
                        $display("%0t: port_value expected %h actual %h",
                                 $time, want.value, m_port_value);
                        mismatches++;
                    end
                    if (m_from_timeout !== want.by_timeout) begin
                        $display("%0t: from_timeout expected %b actual %b",
                                 $time, want.by_timeout, m_from_timeout);
                        mismatches++;
                    end
                end
            end
            m_ready <= calm || ($urandom_range(0, 99) >= 13);
        end
    end

    function automatic host_event_t make_event(cmd_t c);
        host_event_t e;
        e.cmd   = c;
        e.mx    = 8'($urandom_range(0, 255));
        e.my    = 8'($urandom_range(0, 255));
        e.wheel = ($urandom_range(0, 4) == 0) ? 8'sd0 : 8'($urandom_range(0, 255));
        e.btn   = ($urandom_range(0, 2) == 0) ? 3'd0 : 3'($urandom_range(0, 7));
        e.joy   = ($urandom_range(0, 3) == 0) ? JOY_IDLE : 5'($urandom_range(0, 31));
        return e;
    endfunction

    function automatic host_event_t fixed_event(cmd_t c, int x, int y, int w, int b, int j);
        host_event_t e;
        e.cmd   = c;
        e.mx    = 8'(x);
        e.my    = 8'(y);
        e.wheel = 8'(w);
        e.btn   = 3'(b);
        e.joy   = 5'(j);
        return e;
    endfunction

    function automatic logic signed [7:0] big_move(bit neg);
        int v;
        v = $urandom_range(100, 127);
        return neg ? 8'(-v - 1) : 8'(v);
    endfunction

    task automatic push_ticks(int n);
        repeat (n) event_q.push_back(make_event(CMD_TICK));
    endtask

    task automatic add_random_traffic(int n, int tmo);
        int          added;
        int          kind, len, k;
        bit          neg, saturate;
        host_event_t e;
        added = 0;
        while (added < n) begin
            kind = $urandom_range(0, 99);
            if (kind < 35) begin
                // report burst; long bursts drive the accumulators into saturation
                saturate = ($urandom_range(0, 7) == 0);
                len = saturate ? $urandom_range(64, 90) : $urandom_range(1, 4);
                neg = $urandom_range(0, 1);
                for (k = 0; k < len; k++) begin
                    e = make_event(CMD_REPORT);
                    if (saturate) begin
                        e.mx    = big_move(neg);
                        e.my    = big_move(!neg);
                        e.wheel = big_move($urandom_range(0, 1));
                    end else if ($urandom_range(0, 3) == 0) begin
                        // rounds to no movement
                        e.mx    = 8'(int'($urandom_range(0, 3)) - 1);
                        e.my    = 8'(int'($urandom_range(0, 3)) - 1);
                        e.wheel = 8'sd0;
                        e.btn   = 3'd0;
                    end
                    event_q.push_back(e);
                    added++;
                end
            end else if (kind < 70) begin
                // full read sequence, ticks kept below the timeout
                for (k = 0; k < 9; k++) begin
                    event_q.push_back(make_event(CMD_READ));
                    added++;
                    if ($urandom_range(0, 3) == 0) begin
                        len = $urandom_range(1, (tmo < 3) ? tmo : 3);
                        push_ticks(len);
                        added += len;
                    end
                end
            end else if (kind < 85) begin
                // sequence abandoned until the timeout restarts it
                len = $urandom_range(1, 8);
                for (k = 0; k < len; k++)
                    event_q.push_back(make_event(CMD_READ));
                k = tmo + 1 + $urandom_range(0, 2);
                push_ticks(k);
                added += len + k;
            end else begin
                e = make_event(cmd_t'($urandom_range(0, 3)));
                event_q.push_back(e);
                if (e.cmd != CMD_NONE)
                    added++;
            end
        end
    endtask

    task automatic write_reg(logic idx, logic [7:0] data);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_TIMEOUT)
            cfg_timeout = data;
        else
            cfg_present = data[0];
    endtask

    task automatic setup(int tmo, bit present);
        write_reg(REG_TIMEOUT, 8'(tmo));
        write_reg(REG_PRESENT, {7'd0, present});
    endtask

    // settles at the falling edge so that all transfers of the edge are seen
    task automatic wait_quiet();
        do @(negedge aclk);
        while (event_q.size() != 0 || s_valid || port_expect_q.size() != 0);
        repeat (8) @(posedge aclk);
    endtask

    initial begin
        int tmo;
        reset_port_model();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // no mouse: reads hand back the joystick
        event_q.push_back(fixed_event(CMD_READ, 0, 0, 0, 0, 0));
        event_q.push_back(fixed_event(CMD_READ, -1, -1, -1, 7, 31));
        event_q.push_back(fixed_event(CMD_REPORT, 0, 1, 0, 0, 9));
        event_q.push_back(fixed_event(CMD_NONE, 127, -128, 5, 7, 3));
        wait_quiet();

        setup(255, 1'b1);
        // idle mouse and active joystick, then idle joystick starts a sequence
        event_q.push_back(fixed_event(CMD_READ, 0, 0, 0, 0, 0));
        event_q.push_back(fixed_event(CMD_READ, 0, 0, 0, 0, 31));
        for (int k = 0; k < 8; k++)
            event_q.push_back(make_event(CMD_READ));
        event_q.push_back(fixed_event(CMD_REPORT, 127, -128, -128, 5, 0));
        for (int k = 0; k < 9; k++) begin
            event_q.push_back(make_event(CMD_READ));
            if (k == 4)
                event_q.push_back(make_event(CMD_TICK));
        end
        event_q.push_back(fixed_event(CMD_NONE, 0, 0, 0, 0, 0));
        wait_quiet();

        setup(1, 1'b1);
        event_q.push_back(make_event(CMD_READ));
        push_ticks(2);
        add_random_traffic(150, 1);
        wait_quiet();

        tmo = $urandom_range(2, 20);
        setup(tmo, 1'b1);
        calm = 1'b1;
        add_random_traffic(150, tmo);
        wait_quiet();
        calm = 1'b0;
        // leave a sequence half done before the mouse goes away
        if (pm_phase == 0) begin
            event_q.push_back(fixed_event(CMD_REPORT, 9, 9, 1, 7, 0));
            event_q.push_back(make_event(CMD_READ));
            wait_quiet();
        end

        tmo = $urandom_range(3, 10);
        setup(tmo, 1'b0);
        push_ticks(tmo + 1);
        add_random_traffic(80, tmo);
        wait_quiet();

        setup(255, 1'b1);
        add_random_traffic(220, 255);
        wait_quiet();
        repeat (20) @(posedge aclk);

        if (mismatches == 0 && port_expect_q.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial begin
        #400000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
